/* hw/rtl/sst_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sst_pkg: shared types and constants for the sorted set table
// Request and response payloads, command codes, default sizes.
// ----------------------------------------------------------------------------
package sst_pkg;

    localparam int CAPACITY_DEF   = 64;
    localparam int VALUE_BITS_DEF = 32;
    localparam int FIELD_BITS     = 32;
    localparam int INDEX_BITS     = 6;
    localparam int COUNT_BITS     = 7;

    typedef enum logic [1:0] {
        CMD_ADD   = 2'd0,
        CMD_QUERY = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_READ  = 2'd3
    } t_cmd;

    typedef struct packed {
        t_cmd                          command;
        logic signed [FIELD_BITS-1:0]  value;
        logic        [INDEX_BITS-1:0]  index;
    } t_req;

    typedef struct packed {
        logic                          found;
        logic                          added;
        logic                          full_res;
        logic        [COUNT_BITS-1:0]  count;
        logic signed [FIELD_BITS-1:0]  element;
        logic                          element_valid;
    } t_rsp;

    // per-cell control broadcast from the top level
    typedef struct packed {
        logic shift_en;   // commit an insert this cycle
    } t_cell_ctl;

endpackage

/* hw/rtl/sst_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sst_cell: one slot of the sorted row
// Holds one element, compares it against the probe value and, on insert,
// keeps its element, takes the probe, or takes its left neighbor's element.
// ----------------------------------------------------------------------------
module sst_cell #(
    parameter int VALUE_BITS = sst_pkg::VALUE_BITS_DEF
) (
    input  logic                         i_clk,
    input  sst_pkg::t_cell_ctl           i_ctl,
    input  logic                         i_occ,
    input  logic signed [VALUE_BITS-1:0] i_probe,
    input  logic signed [VALUE_BITS-1:0] i_prev_val,
    input  logic                         i_prev_lt,
    output logic signed [VALUE_BITS-1:0] o_val,
    output logic                         o_lt,
    output logic                         o_eq
);
    import sst_pkg::*;

    logic signed [VALUE_BITS-1:0] r_val;
    logic signed [VALUE_BITS-1:0] n_val;

    assign o_lt  = i_occ && (r_val < i_probe);
    assign o_eq  = i_occ && (r_val == i_probe);
    assign o_val = r_val;

    // lt flags form a prefix, so the first non-lt cell is the insert slot
    always_comb begin
        n_val = r_val;
        if (i_ctl.shift_en && !o_lt) begin
            n_val = i_prev_lt ? i_probe : i_prev_val;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

endmodule

/* hw/rtl/sorted_set_table_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_set_table_core: bounded sorted set of signed integers
// Add, query, clear and read-at-index over a row of compare-and-shift cells.
// ----------------------------------------------------------------------------
// Each request is first accepted, when it is captured in a request register,
// and then executed: every cell compares its element with the value at once
// and an add shifts the row by one place. A new request is taken only once
// the previous one has executed, so the block cannot take a request while one
// is still pending; the result sits in an output register, and execute waits
// only if that register still holds an untaken response. Slots above the
// count hold stale data and are never reported.
module sorted_set_table_core #(
    parameter int CAPACITY   = sst_pkg::CAPACITY_DEF,
    parameter int VALUE_BITS = sst_pkg::VALUE_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  sst_pkg::t_req i_req,
    output logic          o_valid,
    input  logic          i_stall,
    output sst_pkg::t_rsp o_rsp
);
    import sst_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);

    t_req                         r_req;
    logic                         r_pend;
    logic                         r_out_valid;
    t_rsp                         r_rsp;
    t_rsp                         n_rsp;
    logic [CW-1:0]                r_count;
    logic [CW-1:0]                n_count;

    logic signed [VALUE_BITS-1:0] probe;
    logic signed [VALUE_BITS-1:0] cell_val [CAPACITY];
    logic        [CAPACITY-1:0]   cell_lt;
    logic        [CAPACITY-1:0]   cell_eq;
    logic        [CAPACITY-1:0]   cell_occ;
    t_cell_ctl                    ctl;

    logic                         exec;
    logic                         found;
    logic                         is_full;
    logic                         idx_ok;
    logic signed [VALUE_BITS-1:0] sel_val;

    assign o_stall = r_pend;
    assign o_valid = r_out_valid;
    assign o_rsp   = r_rsp;

    assign exec    = r_pend && (!r_out_valid || !i_stall);
    assign probe   = VALUE_BITS'(r_req.value);
    assign found   = |cell_eq;
    assign is_full = (r_count == CW'(CAPACITY));
    assign idx_ok  = (32'(r_req.index) < 32'(r_count));

    assign ctl.shift_en = exec && (r_req.command == CMD_ADD) && !found && !is_full;

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
            assign cell_occ[gi] = (32'(gi) < 32'(r_count));
            if (gi == 0) begin : g_head
                sst_cell #(.VALUE_BITS(VALUE_BITS)) u_cell (
                    .i_clk     (i_clk),
                    .i_ctl     (ctl),
                    .i_occ     (cell_occ[gi]),
                    .i_probe   (probe),
                    .i_prev_val(probe),
                    .i_prev_lt (1'b1),
                    .o_val     (cell_val[gi]),
                    .o_lt      (cell_lt[gi]),
                    .o_eq      (cell_eq[gi])
                );
            end else begin : g_body
                sst_cell #(.VALUE_BITS(VALUE_BITS)) u_cell (
                    .i_clk     (i_clk),
                    .i_ctl     (ctl),
                    .i_occ     (cell_occ[gi]),
                    .i_probe   (probe),
                    .i_prev_val(cell_val[gi-1]),
                    .i_prev_lt (cell_lt[gi-1]),
                    .o_val     (cell_val[gi]),
                    .o_lt      (cell_lt[gi]),
                    .o_eq      (cell_eq[gi])
                );
            end
        end
    endgenerate

    // read port: one-hot select over the row
    always_comb begin
        sel_val = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (32'(r_req.index) == i) begin
                sel_val = sel_val | cell_val[i];
            end
        end
    end

    always_comb begin
        n_count = r_count;
        n_rsp   = '0;
        case (r_req.command)
            CMD_ADD: begin
                n_rsp.found    = found;
                n_rsp.added    = ctl.shift_en;
                n_rsp.full_res = !found && is_full;
                if (ctl.shift_en) begin
                    n_count = r_count + CW'(1);
                end
            end
            CMD_QUERY: begin
                n_rsp.found = found;
            end
            CMD_CLEAR: begin
                n_count = '0;
            end
            CMD_READ: begin
                if (idx_ok) begin
                    n_rsp.element       = FIELD_BITS'(sel_val);
                    n_rsp.element_valid = 1'b1;
                end
            end
            default: begin
                n_count = r_count;
            end
        endcase
        n_rsp.count = COUNT_BITS'(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
            r_count     <= '0;
        end else begin
            if (i_valid && !r_pend) begin
                r_pend <= 1'b1;
            end else if (exec) begin
                r_pend <= 1'b0;
            end
            if (exec) begin
                r_out_valid <= 1'b1;
                r_count     <= n_count;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !r_pend) begin
            r_req <= i_req;
        end
        if (exec) begin
            r_rsp <= n_rsp;
        end
    end

endmodule
